[hdl/uer_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg - shared types and constants for the echo ranger
// Field widths, speed-of-sound coefficients, register map and the per-tick
// result record that travels between the sequencer and the averaging stage.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int unsigned TEMP_W    = 8;
	localparam int unsigned TW_W      = 10;
	localparam int unsigned GAP_W     = 16;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned SPEED_W   = 12;
	localparam int unsigned SUM_W     = 31;
	localparam int unsigned DIST_W    = 18;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam int unsigned SHOTS_DEF     = 5;
	localparam int unsigned ECHO_BITS_DEF = 16;

	// speed of sound in 0.1 m/s: base + slope * temperature
	localparam int SPEED_BASE  = 3314;
	localparam int SPEED_SLOPE = 6;

	// one shot contributes speed * width / 2000 in 0.01 cm
	localparam int unsigned DIV_PER_SHOT = 2000;

	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [TW_W-1:0]  TW_RESET  = 10'd20;
	localparam logic [GAP_W-1:0] GAP_RESET = 16'd50000;

	typedef enum logic {
		REG_TRIGGER_WIDTH = 1'b0,
		REG_SHOT_GAP      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic trigger;
		logic busy;
		logic done;
	} res_t;

endpackage : uer_pkg
`default_nettype wire

[hdl/uer_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// uer_seq - shot sequencer and echo accumulator
// Steps the trigger / wait / measure / gap cycle once per tick, weighs each
// echo width by the temperature-corrected speed and keeps the running sum.
// ----------------------------------------------------------------------------
module uer_seq
	import uer_pkg::*;
#(
	parameter int unsigned SHOTS     = SHOTS_DEF,
	parameter int unsigned ECHO_BITS = ECHO_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     proc_en,
	input  wire logic                     start_s1,
	input  wire logic                     echo_s1,
	input  wire logic signed [TEMP_W-1:0] temp_s1,
	input  wire logic [TW_W-1:0]          trigger_width,
	input  wire logic [GAP_W-1:0]         shot_gap,
	output res_t                          res,
	output logic [SUM_W-1:0]              sum_eff
);

	localparam int unsigned PW   = SPEED_W + ECHO_BITS;
	localparam int unsigned AW   = ((PW > SUM_W) ? PW : SUM_W) + 1;
	localparam int unsigned SHW  = $clog2(SHOTS + 1);
	localparam logic [ECHO_BITS-1:0] ECHO_MAX = {ECHO_BITS{1'b1}};
	localparam logic [SHW-1:0]       SHOT_LAST = SHW'(SHOTS);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TRIG = 3'd1,
		PH_WAIT = 3'd2,
		PH_MEAS = 3'd3,
		PH_GAP  = 3'd4
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [TICK_W-1:0]      tick_q;
	logic [ECHO_BITS-1:0]   width_q;
	logic [SHW-1:0]         shot_q;
	logic [SUM_W-1:0]       sum_q;
	logic [PW-1:0]          prod_q;
	logic                   pend_q;

	logic signed [SPEED_W:0] speed_full;
	logic [SPEED_W-1:0]      speed;
	logic [PW-1:0]           prod_d;
	logic [AW-1:0]           sum_ext;
	logic                    done_d;
	logic                    gap_end;

	// speed stays positive for every 8-bit temperature
	assign speed_full = (SPEED_W+1)'(SPEED_BASE)
		+ (SPEED_W+1)'(temp_s1) * (SPEED_W+1)'(SPEED_SLOPE);
	assign speed      = speed_full[SPEED_W-1:0];
	assign prod_d     = PW'(speed) * PW'(width_q);

	// fold in a product that is still pending from the last echo
	assign sum_ext = AW'(sum_q) + AW'(prod_q);
	always_comb begin
		if (!pend_q) begin
			sum_eff = sum_q;
		end else if (sum_ext > AW'(SUM_MAX)) begin
			sum_eff = SUM_MAX;
		end else begin
			sum_eff = sum_ext[SUM_W-1:0];
		end
	end

	assign gap_end = (tick_q >= TICK_W'(shot_gap));

	always_comb begin
		phase_d = phase_q;
		done_d  = 1'b0;
		unique case (phase_q)
			PH_IDLE: if (start_s1) phase_d = PH_TRIG;
			PH_TRIG: if (tick_q >= TICK_W'(trigger_width)) phase_d = PH_WAIT;
			PH_WAIT: if (echo_s1) phase_d = PH_MEAS;
			PH_MEAS: if (!echo_s1) phase_d = PH_GAP;
			PH_GAP: begin
				if (gap_end) begin
					if (shot_q >= SHOT_LAST) begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end else begin
						phase_d = PH_TRIG;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign res.trigger = (phase_d == PH_TRIG);
	assign res.busy    = (phase_d != PH_IDLE);
	assign res.done    = done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			width_q <= '0;
			shot_q  <= '0;
			sum_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (pend_q) begin
				sum_q  <= sum_eff;
				pend_q <= 1'b0;
			end
			if (proc_en) begin
				phase_q <= phase_d;
				unique case (phase_q)
					PH_IDLE: begin
						if (start_s1) begin
							tick_q  <= TICK_W'(1);
							shot_q  <= '0;
							sum_q   <= '0;
							width_q <= '0;
						end
					end
					PH_TRIG: begin
						if (tick_q < TICK_W'(trigger_width)) tick_q <= tick_q + 1'b1;
					end
					PH_WAIT: begin
						if (echo_s1) width_q <= ECHO_BITS'(1);
					end
					PH_MEAS: begin
						if (echo_s1) begin
							if (width_q != ECHO_MAX) width_q <= width_q + 1'b1;
						end else begin
							pend_q <= 1'b1;
							shot_q <= shot_q + 1'b1;
							tick_q <= '0;
						end
					end
					PH_GAP: begin
						if (gap_end) tick_q <= TICK_W'(1);
						else         tick_q <= tick_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// product register: loaded on the echo-fall tick
	always_ff @(posedge clk) begin
		if (proc_en && phase_q == PH_MEAS && !echo_s1) prod_q <= prod_d;
	end

	a_pend_one: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("pending product held more than one cycle");

	a_fall_pends: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_en && phase_q == PH_MEAS && !echo_s1) |=> pend_q && phase_q == PH_GAP)
		else $error("echo fall did not queue a product");

	a_shot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shot_q <= SHOT_LAST)
		else $error("shot index ran past the shot count");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_en && done_d) |=> phase_q == PH_IDLE)
		else $error("done tick left the sequencer busy");

endmodule : uer_seq
`default_nettype wire

[hdl/uer_avg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// uer_avg - average of the shot sum in hundredths of a centimetre
// Divides the sum by 2000*SHOTS with a reciprocal multiply, then saturates; off the done tick it gives zero.
// ----------------------------------------------------------------------------
module uer_avg
	import uer_pkg::*;
#(
	parameter int unsigned SHOTS = SHOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              ld3,
	input  wire logic              ld4,
	input  wire res_t              res_s2,
	input  wire logic [SUM_W-1:0]  sum_s2,
	output res_t                   res_s4,
	output logic [DIST_W-1:0]      dist_s4
);

	localparam longint unsigned DIV = longint'(DIV_PER_SHOT) * longint'(SHOTS);
	localparam int unsigned     K   = SUM_W + $clog2(DIV);
	localparam int unsigned     MW  = SUM_W + 2;
	localparam longint unsigned RECIP = ((64'd1 << K) + DIV - 64'd1) / DIV;
	localparam int unsigned     PRW = SUM_W + MW;
	localparam int unsigned     QW  = PRW - K;

	logic [PRW-1:0] prod_s3;
	res_t           res_s3;
	logic [QW-1:0]  quot;

	assign quot = prod_s3[PRW-1:K];

	always_ff @(posedge clk) begin
		if (ld3) begin
			res_s3  <= res_s2;
			prod_s3 <= PRW'(sum_s2) * PRW'(MW'(RECIP));
		end
		if (ld4) begin
			res_s4 <= res_s3;
			if (!res_s3.done)                 dist_s4 <= '0;
			else if (quot > QW'(DIST_MAX))    dist_s4 <= DIST_MAX;
			else                              dist_s4 <= quot[DIST_W-1:0];
		end
	end

endmodule : uer_avg
`default_nettype wire

[hdl/ultrasonic_echo_ranger.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger - averaged, temperature-compensated echo ranger
// Drives the trigger, times the echo and reports the mean distance of a
// burst of shots.
// ----------------------------------------------------------------------------
// Each input transfer is one microsecond tick: the start request, the
// sampled echo pin and the air temperature in whole degrees C. Every tick
// yields exactly one output transfer showing the trigger pin level, the busy
// flag and, on the done tick, the averaged distance in 0.01 cm (zero on all
// other ticks). One tick is taken per clock cycle, sustained, while the output
// is not stalled; a tick's result passes through the input register, sequencer
// register, reciprocal multiply and saturating output register before it is
// presented. The rate is set by the sequencer state, which advances once per
// tick. Output stall back-pressures the pipeline stage by stage, so ticks keep
// flowing until every stage is full. The temperature is sampled on the tick
// the echo falls. Trigger width and shot gap are written through the APB port
// (byte addresses 0 and 4); the user must write them only while the block is
// idle, which the block does not enforce; a zero trigger width acts as one tick.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int unsigned SHOTS     = SHOTS_DEF,
	parameter int unsigned ECHO_BITS = ECHO_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_AW-1:0]        paddr,
	input  wire logic [APB_DW-1:0]        pwdata,
	output logic      [APB_DW-1:0]        prdata,
	output logic                          pready,
	// tick input
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     start_req,
	input  wire logic                     echo_level,
	input  wire logic signed [TEMP_W-1:0] temperature_c,
	// tick result
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          trigger_level,
	output logic                          busy_res,
	output logic                          done_res,
	output logic [DIST_W-1:0]             distance
);

	logic [TW_W-1:0]  trigger_width_q;
	logic [GAP_W-1:0] shot_gap_q;
	reg_idx_t         reg_sel;
	logic             cfg_wr;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ld2, ld3, ld4;

	logic                     start_s1;
	logic                     echo_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	res_t             res_d, res_s2, res_s4;
	logic [SUM_W-1:0] sum_eff, sum_s2;
	logic [DIST_W-1:0] dist_s4;

	// ---- configuration registers ----
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			REG_TRIGGER_WIDTH: prdata = APB_DW'(trigger_width_q);
			REG_SHOT_GAP:      prdata = APB_DW'(shot_gap_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_width_q <= TW_RESET;
			shot_gap_q      <= GAP_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_TRIGGER_WIDTH: trigger_width_q <= pwdata[TW_W-1:0];
				REG_SHOT_GAP:      shot_gap_q      <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- pipeline flow: a stage loads when empty or when it drains ----
	assign rdy4 = !v_s4 || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign ld2 = v_s1 && rdy2;
	assign ld3 = v_s2 && rdy3;
	assign ld4 = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// capture the tick on transfer
	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			start_s1 <= start_req;
			echo_s1  <= echo_level;
			temp_s1  <= temperature_c;
		end
	end

	// ---- sequencer: advances once per tick as it leaves the input stage ----
	uer_seq #(
		.SHOTS     (SHOTS),
		.ECHO_BITS (ECHO_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.proc_en       (ld2),
		.start_s1      (start_s1),
		.echo_s1       (echo_s1),
		.temp_s1       (temp_s1),
		.trigger_width (trigger_width_q),
		.shot_gap      (shot_gap_q),
		.res           (res_d),
		.sum_eff       (sum_eff)
	);

	// hold the tick result with the sum it saw
	always_ff @(posedge clk) begin
		if (ld2) begin
			res_s2 <= res_d;
			sum_s2 <= sum_eff;
		end
	end

	// ---- averaging and output register ----
	uer_avg #(
		.SHOTS (SHOTS)
	) u_avg (
		.clk     (clk),
		.ld3     (ld3),
		.ld4     (ld4),
		.res_s2  (res_s2),
		.sum_s2  (sum_s2),
		.res_s4  (res_s4),
		.dist_s4 (dist_s4)
	);

	assign out_valid     = v_s4;
	assign trigger_level = res_s4.trigger;
	assign busy_res      = res_s4.busy;
	assign done_res      = res_s4.done;
	assign distance      = dist_s4;

	// ---- checks ----
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("done tick reported busy");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && trigger_level) |-> busy_res)
		else $error("trigger driven outside a sequence");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !done_res) |-> (distance == '0))
		else $error("distance nonzero off the done tick");

endmodule : ultrasonic_echo_ranger
`default_nettype wire
